### rtl/assert_macros.svh
// Assertion macros shared by the route table RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### rtl/dvrt_pkg.sv
// Package for the distance-vector route table: beat types, opcodes, defaults.
// No dependencies.
`default_nettype none
package dvrt_pkg;
   localparam int unsigned TableDepthDefault = 32;
   localparam int unsigned ReportMaxDefault  = 15;
   localparam logic [15:0] TimeoutReset      = 16'd10000;

   typedef enum logic [1:0] {
      OP_HEARD  = 2'd0,
      OP_ADVERT = 2'd1,
      OP_SWEEP  = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_INSTALLED = 2'd0,
      ST_REFRESHED = 2'd1,
      ST_NOCHANGE  = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_OWN_ADDR = 1'b0,
      CSR_TIMEOUT  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] now_ms;
      logic [47:0] sender_addr;
      logic [47:0] target_addr;
      logic [7:0]  adv_hops;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [47:0] entry_target;
      logic [47:0] entry_next_hop;
      logic [7:0]  entry_hops;
      logic        last;
   } rsp_type;

   // one slot as stored in the route memory; via is the neighbor toward target
   typedef struct packed {
      logic [47:0] target;
      logic [47:0] via;
      logic [7:0]  hops;
      logic [31:0] stamp;
   } slot_type;
endpackage
`default_nettype wire

### rtl/dvrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module dvrt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/distance_vector_route_table.sv
// Distance-vector route table top level: control sequencer, valid bits, slot RAM.
// Depends on dvrt_pkg, dvrt_ram and assert_macros.svh.
//
// Usage:
//  - Request channel: pulse req_start with req_data while req_busy is low; the
//    beat is taken at that edge and req_busy rises on the next cycle.
//  - Result channel: each beat sits on rsp_data for one cycle with rsp_valid
//    high; rsp_data.last marks the final beat of a request. The receiver
//    cannot stall, so beats are never held back.
//  - CSR port: csr_wr_en / csr_index / csr_wdata, written at once; index 0 is
//    the own address, index 1 the route timeout in ms. Write only when idle.
//  - Request walk: every request walks all TABLE_DEPTH slots, one RAM
//    read per cycle, then does at most one write-back. For heard, advert
//    and lookup the result beat comes in the first idle cycle. A sweep runs
//    an aging pass, then a report pass; a capped report ends early. The
//    single-read RAM port sets the pace of each walk.
//  - Report beats arrive at most one per cycle during the second sweep pass,
//    own address first; the last beat comes in the first idle cycle.
//  - Reset: synchronous, active high; clears all valid bits at once (the table
//    is empty), restores CSR defaults and returns the sequencer to idle.
`default_nettype none
module distance_vector_route_table
   import dvrt_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TableDepthDefault,
   parameter int unsigned REPORT_MAX  = ReportMaxDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_start,
   input  wire dvrt_pkg::req_type    req_data,
   output logic                      req_busy,
   output logic                      rsp_valid,
   output dvrt_pkg::rsp_type         rsp_data,
   input  wire logic                 csr_wr_en,
   input  wire logic                 csr_index,
   input  wire logic [47:0]          csr_wdata
);
`include "assert_macros.svh"

   localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
   localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned RepW = $clog2(REPORT_MAX + 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(TABLE_DEPTH);
   localparam logic [RepW-1:0] RepMax   = RepW'(REPORT_MAX);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010, // search walk (heard/advert/lookup)
      S_DONE  = 5'b00100, // decide, write back, respond
      S_AGE   = 5'b01000, // sweep: aging pass
      S_REPT  = 5'b10000  // sweep: report pass
   } state_type;

   state_type state_ff, state_in;

   // config registers
   logic [47:0] own_ff;
   logic [15:0] tmo_ff;

   // latched request
   req_type req_ff, req_in;

   // read address counter, and index of the slot whose data is on rd_data
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            rdv_ff, rdv_in;      // rd_data holds a slot from the walk
   logic [IdxW-1:0] rdi_ff, rdi_in;

   // search results
   logic            hit_ff, hit_in;
   logic [IdxW-1:0] hit_idx_ff, hit_idx_in;
   slot_type        hit_slot_ff, hit_slot_in;
   logic            free_ff, free_in;
   logic [IdxW-1:0] free_idx_ff, free_idx_in;

   logic [RepW-1:0] rep_ff, rep_in;     // beats sent in the report
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;

   // RAM
   logic            wr_en;
   logic [IdxW-1:0] wr_addr, rd_addr;
   slot_type        wr_data, rd_data;

   dvrt_ram #(
      .WIDTH($bits(slot_type)),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // beat outputs
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [7:0]  prop_hops;
   logic [31:0] age;
   logic        rd_live;

   assign prop_hops = (req_ff.adv_hops == 8'hFF) ? 8'hFF : req_ff.adv_hops + 8'd1;
   assign age       = req_ff.now_ms - rd_data.stamp;
   assign rd_live   = rdv_ff && valid_ff[rdi_ff];
   assign rd_addr   = cnt_ff[IdxW-1:0];

   assign req_busy  = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic [47:0] key;
      logic        walking;
      state_in    = state_ff;
      req_in      = req_ff;
      cnt_in      = cnt_ff;
      rdv_in      = 1'b0;
      rdi_in      = cnt_ff[IdxW-1:0];
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_slot_in = hit_slot_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      rep_in      = rep_ff;
      valid_in    = valid_ff;
      wr_en       = 1'b0;
      wr_addr     = hit_idx_ff;
      wr_data     = hit_slot_ff;
      rsp_valid_in = 1'b0;
      rsp_in      = '0;
      key = (req_ff.op == OP_HEARD) ? req_ff.sender_addr : req_ff.target_addr;
      walking = (cnt_ff != DepthCnt);

      unique case (state_ff)
         S_IDLE: begin
            if (req_start) begin
               req_in     = req_data;
               cnt_in     = '0;
               hit_in     = 1'b0;
               free_in    = 1'b0;
               rep_in     = '0;
               state_in   = (req_data.op == OP_SWEEP) ? S_AGE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (walking) begin
               cnt_in = cnt_ff + CntW'(1);
               rdv_in = 1'b1;
            end
            if (rd_live && !hit_ff && rd_data.target == key) begin
               hit_in      = 1'b1;
               hit_idx_in  = rdi_ff;
               hit_slot_in = rd_data;
            end
            if (rdv_ff && !valid_ff[rdi_ff] && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = rdi_ff;
            end
            if (!walking && !rdv_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in.last  = 1'b1;
            priority case (req_ff.op)
               OP_HEARD: begin
                  if (req_ff.sender_addr == own_ff) begin
                     rsp_in.status = ST_NOCHANGE;
                  end else if (hit_ff && hit_slot_ff.hops <= 8'd1) begin
                     wr_en   = 1'b1;
                     wr_data = '{hit_slot_ff.target, hit_slot_ff.via,
                                 hit_slot_ff.hops, req_ff.now_ms};
                     rsp_in.status = ST_REFRESHED;
                  end else if (hit_ff || free_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = hit_ff ? hit_idx_ff : free_idx_ff;
                     wr_data = '{req_ff.sender_addr, req_ff.sender_addr, 8'd1,
                                 req_ff.now_ms};
                     valid_in[wr_addr] = 1'b1;
                     rsp_in.status = ST_INSTALLED;
                  end else begin
                     rsp_in.status = ST_FULL;
                  end
               end
               OP_ADVERT: begin
                  if (req_ff.target_addr == own_ff) begin
                     rsp_in.status = ST_NOCHANGE;
                  end else if (!hit_ff) begin
                     if (free_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = free_idx_ff;
                        wr_data = '{req_ff.target_addr, req_ff.sender_addr, prop_hops,
                                    req_ff.now_ms};
                        valid_in[free_idx_ff] = 1'b1;
                        rsp_in.status = ST_INSTALLED;
                     end else begin
                        rsp_in.status = ST_FULL;
                     end
                  end else if (prop_hops < hit_slot_ff.hops) begin
                     wr_en   = 1'b1;
                     wr_data = '{req_ff.target_addr, req_ff.sender_addr, prop_hops,
                                 req_ff.now_ms};
                     rsp_in.status = ST_INSTALLED;
                  end else if (hit_slot_ff.via == req_ff.sender_addr) begin
                     wr_en   = 1'b1;
                     wr_data = '{hit_slot_ff.target, hit_slot_ff.via, prop_hops,
                                 req_ff.now_ms};
                     rsp_in.status = ST_REFRESHED;
                  end else begin
                     rsp_in.status = ST_NOCHANGE;
                  end
               end
               default: begin
                  // lookup
                  rsp_in.entry_target = req_ff.target_addr;
                  if (req_ff.target_addr == own_ff) begin
                     rsp_in.found          = 1'b1;
                     rsp_in.entry_next_hop = own_ff;
                  end else if (hit_ff) begin
                     rsp_in.found          = 1'b1;
                     rsp_in.entry_next_hop = hit_slot_ff.via;
                     rsp_in.entry_hops     = hit_slot_ff.hops;
                  end
               end
            endcase
         end
         S_AGE: begin
            if (walking) begin
               cnt_in = cnt_ff + CntW'(1);
               rdv_in = 1'b1;
            end
            if (rd_live && rd_data.hops != 8'd0 && age > {16'd0, tmo_ff}) begin
               valid_in[rdi_ff] = 1'b0;
            end
            if (!walking && !rdv_ff) begin
               state_in = S_REPT;
               cnt_in   = '0;
               // own address beat
               rsp_valid_in          = 1'b1;
               rsp_in.found          = 1'b1;
               rsp_in.entry_target   = own_ff;
               rsp_in.entry_next_hop = own_ff;
               rep_in                = RepW'(1);
            end
         end
         default: begin
            // S_REPT: hold_ff holds the newest beat; last is set when no more follow
            if (walking && rep_ff != RepMax) begin
               cnt_in = cnt_ff + CntW'(1);
               rdv_in = 1'b1;
            end
            if (rd_live && rep_ff != RepMax) begin
               rsp_valid_in          = 1'b1;
               rsp_in.found          = 1'b1;
               rsp_in.entry_target   = rd_data.target;
               rsp_in.entry_next_hop = rd_data.via;
               rsp_in.entry_hops     = rd_data.hops;
               rep_in                = rep_ff + RepW'(1);
            end
            if ((!walking || rep_ff == RepMax) && !rdv_ff) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // Report beats pass through a hold register so the final one can carry last.
   logic    hold_v_ff;
   rsp_type hold_ff;
   logic    rep_end;
   assign rep_end = (state_ff == S_REPT) && (state_in == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         own_ff       <= '0;
         tmo_ff       <= TimeoutReset;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hold_v_ff    <= 1'b0;
         rdv_ff       <= 1'b0;
         rep_ff       <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rdv_ff   <= rdv_in;
         rep_ff   <= rep_in;
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_OWN_ADDR: own_ff <= csr_wdata;
               default:      tmo_ff <= csr_wdata[15:0];
            endcase
         end
         // sweep beats pass through the hold stage; others go straight out
         if (state_ff == S_AGE || state_ff == S_REPT) begin
            if (rsp_valid_in) begin
               hold_v_ff <= 1'b1;
               hold_ff   <= rsp_in;
               rsp_valid_ff <= hold_v_ff;
               rsp_ff       <= hold_ff;
            end else if (rep_end) begin
               hold_v_ff    <= 1'b0;
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= '{hold_ff.status, hold_ff.found, hold_ff.entry_target,
                                 hold_ff.entry_next_hop, hold_ff.entry_hops, 1'b1};
            end else begin
               rsp_valid_ff <= 1'b0;
            end
         end else begin
            rsp_valid_ff <= rsp_valid_in;
            rsp_ff       <= rsp_in;
         end
      end
      req_ff      <= req_in;
      cnt_ff      <= cnt_in;
      rdi_ff      <= rdi_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_slot_ff <= hit_slot_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
   end

   // a request taken while idle raises req_busy
   `ASSERT_IMPL(a_busy_after_start, clock, reset, req_start && !req_busy, ##1 req_busy)
   // beats flagged last end the request: the hold stage is empty after them
   `ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_valid && rsp_data.last, !hold_v_ff)
   // report never exceeds its cap
   `ASSERT_IMPL(a_rep_cap, clock, reset, 1'b1, rep_ff <= RepMax)
endmodule
`default_nettype wire
